FILE: rtl/core/phit_pkg.sv
`timescale 1ns / 1ps
// phit_pkg: types, constants and edge arithmetic for the polygon hit test core
// no dependencies; imported by the interfaces and every core module

package phit_pkg;

    localparam int XY_W   = 16;
    localparam int DIFF_W = XY_W + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int SQ_W   = PROD_W - 1;
    localparam int DIST_W = PROD_W;
    localparam int TOL_W  = 15;
    localparam int TOL2_W = 2 * TOL_W;
    localparam int IDX_W  = 10;
    localparam int CFG_W  = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [IDX_W-1:0] IDX_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUERY_X   = 2'd0,
        REG_QUERY_Y   = 2'd1,
        REG_TOLERANCE = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic signed [XY_W-1:0] y;
        logic signed [XY_W-1:0] x;
    } t_point;

    typedef struct packed {
        logic signed [XY_W-1:0] vertex_x;
        logic signed [XY_W-1:0] vertex_y;
        logic                   vertex_present;
        logic                   last_of_polygon;
        logic                   last_of_scene;
    } t_item;

    // terms of one edge test; straddle already folds in whether the edge counts
    typedef struct packed {
        logic                     straddle;
        logic                     d_pos;
        logic signed [PROD_W-1:0] lhs;
        logic signed [PROD_W-1:0] rhs;
    } t_edge;

    typedef struct packed {
        logic              near_chk;
        logic              closing;
        logic              end_scene;
        logic              ray_on;
        logic [IDX_W-1:0]  poly;
        logic [SQ_W-1:0]   sq_x;
        logic [SQ_W-1:0]   sq_y;
        logic [TOL2_W-1:0] tol2;
        t_edge             e_step;
        t_edge             e_close;
    } t_stage;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] polygon_index;
        logic             by_proximity;
    } t_hit;

    function automatic logic signed [DIFF_W-1:0] sdiff(
        input logic signed [XY_W-1:0] a,
        input logic signed [XY_W-1:0] b
    );
        return DIFF_W'(a) - DIFF_W'(b);
    endfunction

    function automatic logic signed [PROD_W-1:0] smul(
        input logic signed [DIFF_W-1:0] a,
        input logic signed [DIFF_W-1:0] b
    );
        return PROD_W'(a) * PROD_W'(b);
    endfunction

    // division-free form of the ray crossing: compare cross products instead
    function automatic t_edge edge_terms(
        input t_point                 a,
        input t_point                 b,
        input logic signed [XY_W-1:0] qx,
        input logic signed [XY_W-1:0] qy
    );
        t_edge                    e;
        logic signed [DIFF_W-1:0] d;
        logic signed [DIFF_W-1:0] qa;
        logic signed [DIFF_W-1:0] ba;
        logic signed [DIFF_W-1:0] qya;
        d   = sdiff(b.y, a.y);
        qa  = sdiff(qx, a.x);
        ba  = sdiff(b.x, a.x);
        qya = sdiff(qy, a.y);
        e.straddle = ($signed(a.y) > $signed(qy)) != ($signed(b.y) > $signed(qy));
        e.d_pos    = !d[DIFF_W-1] && (d != '0);
        e.lhs      = smul(qa, d);
        e.rhs      = smul(ba, qya);
        return e;
    endfunction

endpackage

FILE: rtl/core/phit_vertex_if.sv
`timescale 1ns / 1ps
// phit_vertex_if: request channel carrying at most one polygon vertex per request
// depends on phit_pkg for field widths

interface phit_vertex_if import phit_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic signed [XY_W-1:0] vertex_x;
    logic signed [XY_W-1:0] vertex_y;
    logic                   vertex_present;
    logic                   last_of_polygon;
    logic                   last_of_scene;

    modport source (
        output valid, vertex_x, vertex_y, vertex_present, last_of_polygon, last_of_scene,
        input  ready
    );
    modport sink (
        input  valid, vertex_x, vertex_y, vertex_present, last_of_polygon, last_of_scene,
        output ready
    );
endinterface

FILE: rtl/core/phit_hit_if.sv
`timescale 1ns / 1ps
// phit_hit_if: result channel carrying the selected polygon of a scene
// depends on phit_pkg for field widths

interface phit_hit_if import phit_pkg::*;;
    logic             valid;
    logic             ready;
    logic             found;
    logic [IDX_W-1:0] polygon_index;
    logic             by_proximity;

    modport source (
        output valid, found, polygon_index, by_proximity,
        input  ready
    );
    modport sink (
        input  valid, found, polygon_index, by_proximity,
        output ready
    );
endinterface

FILE: rtl/core/phit_front.sv
`timescale 1ns / 1ps
// phit_front: vertex bookkeeping per polygon and all products of one vertex
// depends on phit_pkg; feeds phit_judge through a registered t_stage

module phit_front import phit_pkg::*; #(
    parameter int MAX_VERTICES = 1000,
    parameter int MAX_POLYGONS = 1000
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_item_valid,
    input  t_item                   i_item,
    input  logic signed [XY_W-1:0]  i_query_x,
    input  logic signed [XY_W-1:0]  i_query_y,
    input  logic [TOL_W-1:0]        i_tolerance,
    output t_stage                  o_stage
);

    localparam int CNT_W = $clog2(MAX_VERTICES + 1);

    logic [CNT_W-1:0] r_count, n_count;
    logic             r_past, n_past;
    logic [IDX_W-1:0] r_poly, n_poly;
    t_point           r_first, n_first;
    t_point           r_prev, n_prev;
    t_stage           r_stage, n_stage;

    t_point                   cur;
    logic                     ray_on;
    logic                     do_vtx;
    logic                     closing;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [PROD_W-1:0] px;
    logic signed [PROD_W-1:0] py;

    always_comb begin
        cur.x   = i_item.vertex_x;
        cur.y   = i_item.vertex_y;
        ray_on  = r_poly < IDX_W'(MAX_POLYGONS);
        do_vtx  = i_item_valid && i_item.vertex_present && !r_past;
        closing = i_item_valid && (!i_item.vertex_present || i_item.last_of_polygon
                                   || i_item.last_of_scene);

        n_count = r_count;
        n_past  = r_past;
        n_first = r_first;
        n_prev  = r_prev;
        n_poly  = r_poly;

        if (do_vtx) begin
            if (r_count == '0) begin
                n_first = cur;
            end
            n_prev = cur;
            if (r_count < CNT_W'(MAX_VERTICES)) begin
                n_count = r_count + CNT_W'(1);
            end else begin
                n_past = 1'b1;
            end
        end

        dx = sdiff(i_item.vertex_x, i_query_x);
        dy = sdiff(i_item.vertex_y, i_query_y);
        px = smul(dx, dx);
        py = smul(dy, dy);

        n_stage.near_chk  = do_vtx && (r_count < CNT_W'(MAX_VERTICES));
        n_stage.closing   = closing;
        n_stage.end_scene = i_item_valid && i_item.last_of_scene;
        n_stage.ray_on    = ray_on;
        n_stage.poly      = r_poly;
        n_stage.sq_x      = px[SQ_W-1:0];
        n_stage.sq_y      = py[SQ_W-1:0];
        n_stage.tol2      = TOL2_W'(i_tolerance) * TOL2_W'(i_tolerance);

        n_stage.e_step = edge_terms(r_prev, cur, i_query_x, i_query_y);
        n_stage.e_step.straddle = n_stage.e_step.straddle && do_vtx
                                  && (r_count != '0) && ray_on;

        // closing edge runs from the last kept vertex back to the first
        n_stage.e_close = edge_terms(n_prev, n_first, i_query_x, i_query_y);
        n_stage.e_close.straddle = n_stage.e_close.straddle && closing && ray_on
                                   && (n_count != '0) && !n_past;

        if (closing) begin
            n_count = '0;
            n_past  = 1'b0;
            n_poly  = (r_poly != IDX_MAX) ? r_poly + IDX_W'(1) : r_poly;
            if (i_item.last_of_scene) begin
                n_poly = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_past  <= 1'b0;
            r_poly  <= '0;
            r_stage <= '0;
        end else if (i_en) begin
            r_count <= n_count;
            r_past  <= n_past;
            r_poly  <= n_poly;
            r_stage <= n_stage;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_first <= n_first;
            r_prev  <= n_prev;
        end
    end

    assign o_stage = r_stage;

endmodule

FILE: rtl/core/phit_judge.sv
`timescale 1ns / 1ps
// phit_judge: distance and crossing compares, parity and first-hit tracking
// depends on phit_pkg; takes t_stage from phit_front, gives a t_hit result

module phit_judge import phit_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  t_stage i_stage,
    output logic   o_res_valid,
    output t_hit   o_res
);

    logic             r_parity, n_parity;
    logic             r_near_v, n_near_v;
    logic [IDX_W-1:0] r_near_idx, n_near_idx;
    logic             r_ins_v, n_ins_v;
    logic [IDX_W-1:0] r_ins_idx, n_ins_idx;

    logic [DIST_W-1:0] dist_sq;
    logic              near;
    logic              par_step;
    logic              par_close;

    function automatic logic crosses(input t_edge e);
        logic signed [PROD_W-1:0] l;
        logic signed [PROD_W-1:0] r;
        l = e.lhs;
        r = e.rhs;
        return e.straddle && (e.d_pos ? (l < r) : (l > r));
    endfunction

    always_comb begin
        dist_sq = DIST_W'(i_stage.sq_x) + DIST_W'(i_stage.sq_y);
        near    = i_stage.near_chk && (dist_sq <= DIST_W'(i_stage.tol2));

        n_parity   = r_parity;
        n_near_v   = r_near_v;
        n_near_idx = r_near_idx;
        n_ins_v    = r_ins_v;
        n_ins_idx  = r_ins_idx;

        if (near && !r_near_v) begin
            n_near_v   = 1'b1;
            n_near_idx = i_stage.poly;
        end

        par_step  = r_parity ^ crosses(i_stage.e_step);
        par_close = par_step ^ crosses(i_stage.e_close);
        n_parity  = par_step;

        if (i_stage.closing) begin
            if (i_stage.ray_on && par_close && !r_ins_v) begin
                n_ins_v   = 1'b1;
                n_ins_idx = i_stage.poly;
            end
            n_parity = 1'b0;
        end

        o_res_valid = i_stage.end_scene;
        if (n_near_v) begin
            o_res.found         = 1'b1;
            o_res.polygon_index = n_near_idx;
            o_res.by_proximity  = 1'b1;
        end else if (n_ins_v) begin
            o_res.found         = 1'b1;
            o_res.polygon_index = n_ins_idx;
            o_res.by_proximity  = 1'b0;
        end else begin
            o_res = '0;
        end

        // scene done: start the next one clean
        if (i_stage.end_scene) begin
            n_parity   = 1'b0;
            n_near_v   = 1'b0;
            n_near_idx = '0;
            n_ins_v    = 1'b0;
            n_ins_idx  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parity   <= 1'b0;
            r_near_v   <= 1'b0;
            r_near_idx <= '0;
            r_ins_v    <= 1'b0;
            r_ins_idx  <= '0;
        end else if (i_en) begin
            r_parity   <= n_parity;
            r_near_v   <= n_near_v;
            r_near_idx <= n_near_idx;
            r_ins_v    <= n_ins_v;
            r_ins_idx  <= n_ins_idx;
        end
    end

endmodule

FILE: rtl/core/polygon_hit_test_core.sv
`timescale 1ns / 1ps
// polygon_hit_test_core: picks a polygon by vertex proximity or ray casting
// path: a scene's last vertex request moves from the input register to the product
// stage register, and the compare stage result is then registered onto o_hit
// throughput: one vertex request per cycle; input register, product stage and
// compare stage advance together and hold only while the result waits unread
// reset (synchronous, active low) clears the query, tolerance and scene state
// depends on phit_pkg, phit_vertex_if, phit_hit_if, phit_front, phit_judge

module polygon_hit_test_core import phit_pkg::*; #(
    parameter int MAX_VERTICES = 1000,
    parameter int MAX_POLYGONS = 1000
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    phit_vertex_if.sink          i_vertex,
    phit_hit_if.source           o_hit
);

    logic signed [XY_W-1:0] r_query_x;
    logic signed [XY_W-1:0] r_query_y;
    logic [TOL_W-1:0]       r_tolerance;

    logic   en;
    logic   r_in_valid;
    t_item  r_in;
    t_stage stage;
    logic   res_valid;
    t_hit   res;
    logic   r_out_valid;
    t_hit   r_out;

    // the whole pipe moves unless a finished result is still unread
    assign en             = !r_out_valid || o_hit.ready;
    assign i_vertex.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query_x   <= '0;
            r_query_y   <= '0;
            r_tolerance <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_QUERY_X:   r_query_x   <= i_cfg_data;
                REG_QUERY_Y:   r_query_y   <= i_cfg_data;
                REG_TOLERANCE: r_tolerance <= i_cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_in_valid  <= i_vertex.valid;
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in.vertex_x        <= i_vertex.vertex_x;
            r_in.vertex_y        <= i_vertex.vertex_y;
            r_in.vertex_present  <= i_vertex.vertex_present;
            r_in.last_of_polygon <= i_vertex.last_of_polygon;
            r_in.last_of_scene   <= i_vertex.last_of_scene;
            r_out                <= res;
        end
    end

    phit_front #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_POLYGONS (MAX_POLYGONS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_item_valid (r_in_valid),
        .i_item       (r_in),
        .i_query_x    (r_query_x),
        .i_query_y    (r_query_y),
        .i_tolerance  (r_tolerance),
        .o_stage      (stage)
    );

    phit_judge u_judge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_stage     (stage),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    assign o_hit.valid         = r_out_valid;
    assign o_hit.found         = r_out.found;
    assign o_hit.polygon_index = r_out.polygon_index;
    assign o_hit.by_proximity  = r_out.by_proximity;

endmodule
